// ===== hw/rtl/bfp_pkg.sv =====
// Shared types and constants for the battery cell fault protector.
// No dependencies; imported by every module of the block.
`default_nettype none

package bfp_pkg;

  localparam int FLG_TEMP  = 0;
  localparam int FLG_VHIGH = 1;
  localparam int FLG_VLOW  = 2;
  localparam int FLG_CIN   = 3;
  localparam int FLG_COUT  = 4;
  localparam int FLG_LOWC  = 5;

  localparam logic [5:0] FAULT_MASK = 6'b011111;

  typedef enum logic [2:0] {
    CFG_TEMP_TRIP      = 3'd0,
    CFG_TEMP_RECOVER   = 3'd1,
    CFG_VHIGH_TRIP     = 3'd2,
    CFG_VHIGH_RECOVER  = 3'd3,
    CFG_VLOW_TRIP      = 3'd4,
    CFG_VLOW_RECOVER   = 3'd5,
    CFG_CURRENT_TRIP   = 3'd6,
    CFG_CURRENT_RETEST = 3'd7
  } cfg_idx_e;

  localparam logic [15:0] RST_TEMP_TRIP      = 16'd6000;
  localparam logic [15:0] RST_TEMP_RECOVER   = 16'd4500;
  localparam logic [15:0] RST_VHIGH_TRIP     = 16'd4200;
  localparam logic [15:0] RST_VHIGH_RECOVER  = 16'd4100;
  localparam logic [15:0] RST_VLOW_TRIP      = 16'd3000;
  localparam logic [15:0] RST_VLOW_RECOVER   = 16'd3200;
  localparam logic [15:0] RST_CURRENT_TRIP   = 16'd10000;
  localparam logic [15:0] RST_CURRENT_RETEST = 16'd8000;

  typedef struct packed {
    logic [15:0] temp_trip;
    logic [15:0] temp_recover;
    logic [15:0] volt_high_trip;
    logic [15:0] volt_high_recover;
    logic [15:0] volt_low_trip;
    logic [15:0] volt_low_recover;
    logic [15:0] current_trip;
    logic [15:0] current_retest_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] cell_temperature;
    logic [15:0] cell_voltage;
    logic [15:0] charge_current;
    logic [15:0] discharge_current;
  } meas_t;

  typedef struct packed {
    logic       fault_active;
    logic [5:0] fault_flags;
    logic       discharge_relay_closed;
    logic       charge_relay_closed;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfp_cfg.sv =====
// Threshold register file, written through the configuration request channel.
// Depends on bfp_pkg.
`default_nettype none

module bfp_cfg
  import bfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_trip            <= RST_TEMP_TRIP;
      cfg.temp_recover         <= RST_TEMP_RECOVER;
      cfg.volt_high_trip       <= RST_VHIGH_TRIP;
      cfg.volt_high_recover    <= RST_VHIGH_RECOVER;
      cfg.volt_low_trip        <= RST_VLOW_TRIP;
      cfg.volt_low_recover     <= RST_VLOW_RECOVER;
      cfg.current_trip         <= RST_CURRENT_TRIP;
      cfg.current_retest_limit <= RST_CURRENT_RETEST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_TEMP_TRIP:      cfg.temp_trip            <= cfg_data;
        CFG_TEMP_RECOVER:   cfg.temp_recover         <= cfg_data;
        CFG_VHIGH_TRIP:     cfg.volt_high_trip       <= cfg_data;
        CFG_VHIGH_RECOVER:  cfg.volt_high_recover    <= cfg_data;
        CFG_VLOW_TRIP:      cfg.volt_low_trip        <= cfg_data;
        CFG_VLOW_RECOVER:   cfg.volt_low_recover     <= cfg_data;
        CFG_CURRENT_TRIP:   cfg.current_trip         <= cfg_data;
        CFG_CURRENT_RETEST: cfg.current_retest_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfp_core.sv =====
// Fault state registers and the single-pass update for one measurement set.
// Depends on bfp_pkg.
`default_nettype none

module bfp_core
  import bfp_pkg::*;
#(
  parameter int TRIGGER_COUNT    = 8,
  parameter int CYCLE_COUNT      = 64,
  parameter int LOW_CURRENT_WARN = 100
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  cfg_t      cfg,
  input  meas_t     meas,
  output result_t   res
);

  localparam int TW  = $clog2(TRIGGER_COUNT + 1);
  localparam int OCW = $clog2(2 * CYCLE_COUNT + 2);
  localparam int CW  = (OCW > TW) ? OCW : TW;

  localparam logic [CW-1:0] TRIG = CW'(TRIGGER_COUNT);
  localparam logic [CW-1:0] CYC  = CW'(CYCLE_COUNT);
  localparam logic [CW-1:0] CYC2 = CW'(2 * CYCLE_COUNT);
  localparam logic [15:0]   LOWC = 16'(LOW_CURRENT_WARN);

  logic [5:0]    flags, flags_next;
  logic [TW-1:0] ot_cnt, ov_cnt, uv_cnt;
  logic [TW-1:0] ot_cnt_next, ov_cnt_next, uv_cnt_next;
  logic [CW-1:0] ci_cnt, co_cnt, ci_cnt_next, co_cnt_next;
  logic          charge_relay, discharge_relay;
  logic          charge_relay_next, discharge_relay_next;
  logic [CW:0]   d_ot, d_ov, d_uv, d_ci, d_co;

  // {hit, count}; count clears when the trigger level is reached
  function automatic logic [CW:0] debounce(input logic [CW-1:0] cnt, input logic cond);
    logic [CW-1:0] n;
    n = cond ? cnt + 1'b1 : ((cnt != '0) ? cnt - 1'b1 : cnt);
    if (n >= TRIG) return {1'b1, {CW{1'b0}}};
    return {1'b0, n};
  endfunction

  always_comb begin
    flags_next           = flags;
    ot_cnt_next          = ot_cnt;
    ov_cnt_next          = ov_cnt;
    uv_cnt_next          = uv_cnt;
    ci_cnt_next          = ci_cnt;
    co_cnt_next          = co_cnt;
    charge_relay_next    = charge_relay;
    discharge_relay_next = discharge_relay;
    d_ot = '0;
    d_ov = '0;
    d_uv = '0;
    d_ci = '0;
    d_co = '0;

    flags_next[FLG_LOWC] = meas.charge_current < LOWC;

    if (!flags_next[FLG_TEMP]) begin
      d_ot = debounce(CW'(ot_cnt),
                      $signed(meas.cell_temperature) > $signed(cfg.temp_trip));
      if (d_ot[CW]) begin
        charge_relay_next    = 1'b0;
        discharge_relay_next = 1'b0;
        flags_next[FLG_TEMP] = 1'b1;
      end
    end else begin
      d_ot = debounce(CW'(ot_cnt),
                      $signed(meas.cell_temperature) < $signed(cfg.temp_recover));
      if (d_ot[CW]) flags_next[FLG_TEMP] = 1'b0;
    end
    ot_cnt_next = d_ot[TW-1:0];

    if (!flags_next[FLG_VHIGH]) begin
      d_ov = debounce(CW'(ov_cnt), meas.cell_voltage > cfg.volt_high_trip);
      if (d_ov[CW]) begin
        charge_relay_next     = 1'b0;
        flags_next[FLG_VHIGH] = 1'b1;
      end
    end else begin
      d_ov = debounce(CW'(ov_cnt), meas.cell_voltage < cfg.volt_high_recover);
      if (d_ov[CW]) flags_next[FLG_VHIGH] = 1'b0;
    end
    ov_cnt_next = d_ov[TW-1:0];

    if (!flags_next[FLG_VLOW]) begin
      d_uv = debounce(CW'(uv_cnt), meas.cell_voltage < cfg.volt_low_trip);
      if (d_uv[CW]) begin
        discharge_relay_next = 1'b0;
        flags_next[FLG_VLOW] = 1'b1;
      end
    end else begin
      d_uv = debounce(CW'(uv_cnt), meas.cell_voltage > cfg.volt_low_recover);
      if (d_uv[CW]) flags_next[FLG_VLOW] = 1'b0;
    end
    uv_cnt_next = d_uv[TW-1:0];

    // charge side over-current, frozen under over-temperature or over-voltage
    if (!flags_next[FLG_VHIGH] && !flags_next[FLG_TEMP]) begin
      if (!flags_next[FLG_CIN]) begin
        d_ci = debounce(ci_cnt, meas.charge_current > cfg.current_trip);
        ci_cnt_next = d_ci[CW-1:0];
        if (d_ci[CW]) begin
          charge_relay_next   = 1'b0;
          flags_next[FLG_CIN] = 1'b1;
        end
      end else begin
        ci_cnt_next = ci_cnt + 1'b1;
        if (ci_cnt_next == CYC) charge_relay_next = 1'b1;
        if (ci_cnt_next > CYC && meas.charge_current > cfg.current_retest_limit) begin
          charge_relay_next = 1'b0;
          ci_cnt_next       = '0;
        end
        if (ci_cnt_next > CYC2) begin
          flags_next[FLG_CIN] = 1'b0;
          ci_cnt_next         = '0;
        end
      end
    end

    // discharge side, frozen under over-temperature or under-voltage
    if (!flags_next[FLG_VLOW] && !flags_next[FLG_TEMP]) begin
      if (!flags_next[FLG_COUT]) begin
        d_co = debounce(co_cnt, meas.discharge_current > cfg.current_trip);
        co_cnt_next = d_co[CW-1:0];
        if (d_co[CW]) begin
          discharge_relay_next = 1'b0;
          flags_next[FLG_COUT] = 1'b1;
        end
      end else begin
        co_cnt_next = co_cnt + 1'b1;
        if (co_cnt_next == CYC) discharge_relay_next = 1'b1;
        if (co_cnt_next > CYC && meas.discharge_current > cfg.current_retest_limit) begin
          discharge_relay_next = 1'b0;
          co_cnt_next          = '0;
        end
        if (co_cnt_next > CYC2) begin
          flags_next[FLG_COUT] = 1'b0;
          co_cnt_next          = '0;
        end
      end
    end

    if (!(flags_next[FLG_TEMP] || flags_next[FLG_VLOW] || flags_next[FLG_COUT]))
      discharge_relay_next = 1'b1;
    if (!(flags_next[FLG_TEMP] || flags_next[FLG_VHIGH] || flags_next[FLG_CIN]))
      charge_relay_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags           <= '0;
      ot_cnt          <= '0;
      ov_cnt          <= '0;
      uv_cnt          <= '0;
      ci_cnt          <= '0;
      co_cnt          <= '0;
      charge_relay    <= 1'b1;
      discharge_relay <= 1'b1;
    end else if (step) begin
      flags           <= flags_next;
      ot_cnt          <= ot_cnt_next;
      ov_cnt          <= ov_cnt_next;
      uv_cnt          <= uv_cnt_next;
      ci_cnt          <= ci_cnt_next;
      co_cnt          <= co_cnt_next;
      charge_relay    <= charge_relay_next;
      discharge_relay <= discharge_relay_next;
    end
  end

  assign res.charge_relay_closed    = charge_relay_next;
  assign res.discharge_relay_closed = discharge_relay_next;
  assign res.fault_flags            = flags_next;
  assign res.fault_active           = |(flags_next & FAULT_MASK);

  a_trip_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(ot_cnt) < TRIG && CW'(ov_cnt) < TRIG && CW'(uv_cnt) < TRIG)
    else $error("debounce counter reached trigger level");

  a_oc_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    ci_cnt <= CYC2 && co_cnt <= CYC2)
    else $error("over-current counter beyond recovery window");

  a_temp_opens: assert property (@(posedge clk) disable iff (rst)
    flags[FLG_TEMP] |-> !charge_relay && !discharge_relay)
    else $error("relay closed under over-temperature");

  a_charge_reclose: assert property (@(posedge clk) disable iff (rst)
    !(flags[FLG_TEMP] || flags[FLG_VHIGH] || flags[FLG_CIN]) |-> charge_relay)
    else $error("charge relay open without a fault");

  a_discharge_reclose: assert property (@(posedge clk) disable iff (rst)
    !(flags[FLG_TEMP] || flags[FLG_VLOW] || flags[FLG_COUT]) |-> discharge_relay)
    else $error("discharge relay open without a fault");

endmodule

`default_nettype wire

// ===== hw/rtl/battery_cell_fault_protector.sv =====
// Battery cell fault protector: input register, fault core, result register.
// A request is held in the input register, then its result is registered in res_q as m_tvalid rises.
// One request per cycle while m_tready keeps m_tvalid from stalling; bfp_core updates state once per request.
// Synchronous reset: thresholds to defaults, flags and counters clear, relays closed.
// Depends on bfp_pkg, bfp_cfg, bfp_core.
`default_nettype none

module battery_cell_fault_protector
  import bfp_pkg::*;
#(
  parameter int TRIGGER_COUNT    = 8,
  parameter int CYCLE_COUNT      = 64,
  parameter int LOW_CURRENT_WARN = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [15:0] cell_temperature, [31:16] cell_voltage,
  // [47:32] charge_current, [63:48] discharge_current
  input  wire logic [63:0] s_tdata,
  // [0] op
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] charge_relay_closed, [1] discharge_relay_closed,
  // [7:2] fault_flags, [8] fault_active, [15:9] zero
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t    cfg;
  meas_t   meas;
  result_t res, res_q;
  logic    in_valid, advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // op carries a single code, so every request is a measurement step
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      meas.cell_temperature  <= s_tdata[15:0];
      meas.cell_voltage      <= s_tdata[31:16];
      meas.charge_current    <= s_tdata[47:32];
      meas.discharge_current <= s_tdata[63:48];
    end
  end

  bfp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bfp_core #(
    .TRIGGER_COUNT    (TRIGGER_COUNT),
    .CYCLE_COUNT      (CYCLE_COUNT),
    .LOW_CURRENT_WARN (LOW_CURRENT_WARN)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cfg  (cfg),
    .meas (meas),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= res;
  end

  assign m_tdata = {7'd0, res_q};

endmodule

`default_nettype wire
